FILE: rtl/rpa_pkg.sv
// Shared types, codes and defaults for the rectilinear polygon area block.
package rpa_pkg;

  // Default geometry of the datapath.
  localparam int COORD_BITS_DEF = 32;
  localparam int STEP_BITS_DEF  = 20;

  // Width of the step count carried by either input form.
  localparam int CODE_STEP_BITS = 20;

  // Width of all result sums.
  localparam int SUM_BITS = 64;

  // Move directions; y grows downward.
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // One input beat.
  typedef struct packed {
    logic [1:0]                direction;
    logic [CODE_STEP_BITS-1:0] move_steps;
    logic [23:0]               raw_code;
    logic                      last_move;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [SUM_BITS-1:0] lattice_count;
    logic [SUM_BITS-1:0] doubled_area;
    logic [SUM_BITS-1:0] boundary_length;
    logic                overflow;
  } out_beat_t;

  // Control that travels with a product from the move stage to the accumulator.
  typedef struct packed {
    logic valid;
    logic horiz;
    logic neg;
    logic last;
    logic flag;
  } mul_ctl_t;

  // Closing snapshot of the accumulators for one polygon.
  typedef struct packed {
    logic [SUM_BITS-1:0] area;
    logic [SUM_BITS-1:0] perim;
    logic                ovf;
  } snap_t;

endpackage

FILE: rtl/rpa_move.sv
// Move decode, position tracking and area product for the polygon block.
module rpa_move #(
  parameter int COORD_BITS = rpa_pkg::COORD_BITS_DEF,
  parameter int STEP_BITS  = rpa_pkg::STEP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic                          in_valid,
  input  rpa_pkg::in_beat_t             in_beat,
  input  logic                          encoded_mode,
  output rpa_pkg::mul_ctl_t             ctl_o,
  output logic [COORD_BITS+STEP_BITS-1:0] prod_o,
  output logic [STEP_BITS-1:0]          steps_o
);
  import rpa_pkg::*;

  localparam int PW = COORD_BITS + STEP_BITS;
  localparam int SX = (STEP_BITS > CODE_STEP_BITS) ? STEP_BITS : CODE_STEP_BITS;
  localparam int NW = ((COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS) + 2;

  // Input register.
  logic                 v0_r;
  dir_t                 dir0_r;
  logic [STEP_BITS-1:0] steps0_r;
  logic                 last0_r;

  // Position state.
  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic [COORD_BITS-1:0] yabs_r, yabs_nxt;

  // Product register.
  mul_ctl_t             ctl_r, ctl_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [STEP_BITS-1:0] steps_r;

  // Decode of the accepted beat.
  logic [CODE_STEP_BITS-1:0] raw_steps;
  logic [SX-1:0]             steps_ext;
  dir_t                      dir_dec;
  logic [3:0]                nib;

  // Position arithmetic.
  logic                  horiz;
  logic                  fwd;
  logic [COORD_BITS-1:0] coord;
  logic [NW-1:0]         coord_ext;
  logic [NW-1:0]         step_ext;
  logic [NW-1:0]         n;
  logic [COORD_BITS-1:0] n_cut;
  logic                  pos_ovf;

  // Pick the move from either the plain fields or the packed code.
  always_comb begin
    nib = in_beat.raw_code[3:0];
    if (encoded_mode) begin
      raw_steps = in_beat.raw_code[23:4];
      if (nib > 4'(DIR_LEFT)) begin
        dir_dec = DIR_UP;
      end else begin
        dir_dec = dir_t'(nib[1:0]);
      end
    end else begin
      raw_steps = in_beat.move_steps;
      dir_dec   = dir_t'(in_beat.direction);
    end
    steps_ext = SX'(raw_steps);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (advance) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      dir0_r   <= dir_dec;
      steps0_r <= steps_ext[STEP_BITS-1:0];
      last0_r  <= in_beat.last_move;
    end
  end

  // Step the moving coordinate and flag a leave of the signed range.
  always_comb begin
    horiz     = (dir0_r == DIR_RIGHT) || (dir0_r == DIR_LEFT);
    fwd       = (dir0_r == DIR_RIGHT) || (dir0_r == DIR_DOWN);
    coord     = horiz ? x_r : y_r;
    coord_ext = {{(NW-COORD_BITS){coord[COORD_BITS-1]}}, coord};
    step_ext  = {{(NW-STEP_BITS){1'b0}}, steps0_r};
    n         = fwd ? (coord_ext + step_ext) : (coord_ext - step_ext);
    n_cut     = n[COORD_BITS-1:0];
    pos_ovf   = !((&n[NW-1:COORD_BITS-1]) || !(|n[NW-1:COORD_BITS-1]));
  end

  // Next position; a closing move returns to the origin.
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    yabs_nxt = yabs_r;
    if (v0_r) begin
      if (last0_r) begin
        x_nxt    = '0;
        y_nxt    = '0;
        yabs_nxt = '0;
      end else if (horiz) begin
        x_nxt = n_cut;
      end else begin
        y_nxt    = n_cut;
        yabs_nxt = n_cut[COORD_BITS-1] ? (COORD_BITS'(0) - n_cut) : n_cut;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      yabs_r <= '0;
    end else if (advance) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      yabs_r <= yabs_nxt;
    end
  end

  // Magnitude product |y| * steps and its sign for the shoelace term.
  always_comb begin
    prod_nxt      = PW'(yabs_r) * PW'(steps0_r);
    ctl_nxt.valid = v0_r;
    ctl_nxt.horiz = horiz;
    ctl_nxt.neg   = y_r[COORD_BITS-1] ^ (dir0_r == DIR_LEFT);
    ctl_nxt.last  = last0_r;
    ctl_nxt.flag  = pos_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (advance) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v0_r) begin
      prod_r  <= prod_nxt;
      steps_r <= steps0_r;
    end
  end

  assign ctl_o   = ctl_r;
  assign prod_o  = prod_r;
  assign steps_o = steps_r;

  // The stored magnitude always tracks the signed y position.
  a_yabs_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    yabs_r == (y_r[COORD_BITS-1] ? (COORD_BITS'(0) - y_r) : y_r))
    else $error("y magnitude out of step with y position");

  // A closing move leaves the position at the origin.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v0_r && last0_r) |=> (x_r == '0 && y_r == '0))
    else $error("position not cleared after closing move");

  // Position only changes when a move advances through the stage.
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && v0_r) |=> ($stable(x_r) && $stable(y_r)))
    else $error("position changed without a move");

endmodule

FILE: rtl/rpa_accum.sv
// Area and perimeter accumulators with sticky overflow tracking.
module rpa_accum #(
  parameter int COORD_BITS = rpa_pkg::COORD_BITS_DEF,
  parameter int STEP_BITS  = rpa_pkg::STEP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  rpa_pkg::mul_ctl_t               ctl_i,
  input  logic [COORD_BITS+STEP_BITS-1:0] prod_i,
  input  logic [STEP_BITS-1:0]            steps_i,
  output logic                            snap_valid_o,
  output rpa_pkg::snap_t                  snap_o
);
  import rpa_pkg::*;

  localparam int PW = COORD_BITS + STEP_BITS;
  localparam int EW = (PW > SUM_BITS) ? PW : SUM_BITS;
  localparam logic [EW-1:0] QUARTER = {{(EW-63){1'b0}}, 1'b1, {62{1'b0}}};

  logic [SUM_BITS-1:0] area_r, area_nxt;
  logic [SUM_BITS-1:0] perim_r;
  logic                ovfs_r;
  logic                snap_valid_r;
  snap_t               snap_r;

  logic [EW-1:0]       pe;
  logic [SUM_BITS-1:0] mag;
  logic [SUM_BITS-1:0] term;
  logic [SUM_BITS-1:0] area_sum;
  logic                mul_big;
  logic                add_ovf;
  logic [SUM_BITS:0]   perim_sum;
  logic                ovf_nxt;

  // Shoelace term and the overflow checks on product, doubling and sum.
  always_comb begin
    pe       = EW'(prod_i);
    mag      = {pe[62:0], 1'b0};
    term     = ctl_i.neg ? (SUM_BITS'(0) - mag) : mag;
    area_sum = area_r + term;
    mul_big  = (pe > QUARTER) || ((pe == QUARTER) && !ctl_i.neg);
    add_ovf  = !(area_r[SUM_BITS-1] ^ term[SUM_BITS-1]) &&
               (area_sum[SUM_BITS-1] ^ area_r[SUM_BITS-1]);
    area_nxt = ctl_i.horiz ? area_sum : area_r;
    perim_sum = {1'b0, perim_r} + (SUM_BITS+1)'(steps_i);
    ovf_nxt  = ovfs_r || ctl_i.flag || perim_sum[SUM_BITS] ||
               (ctl_i.horiz && (mul_big || add_ovf));
  end

  // Accumulate, or hand off the totals and restart on a closing move.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r  <= '0;
      perim_r <= '0;
      ovfs_r  <= 1'b0;
    end else if (advance && ctl_i.valid) begin
      if (ctl_i.last) begin
        area_r  <= '0;
        perim_r <= '0;
        ovfs_r  <= 1'b0;
      end else begin
        area_r  <= area_nxt;
        perim_r <= perim_sum[SUM_BITS-1:0];
        ovfs_r  <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (advance) begin
      snap_valid_r <= ctl_i.valid && ctl_i.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctl_i.valid && ctl_i.last) begin
      snap_r.area  <= area_nxt;
      snap_r.perim <= perim_sum[SUM_BITS-1:0];
      snap_r.ovf   <= ovf_nxt;
    end
  end

  assign snap_valid_o = snap_valid_r;
  assign snap_o       = snap_r;

  // A closing move restarts every accumulator.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ctl_i.valid && ctl_i.last) |=>
      (area_r == '0 && perim_r == '0 && !ovfs_r))
    else $error("accumulators not cleared after closing move");

  // Overflow stays set until the polygon closes.
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ovfs_r && !(advance && ctl_i.valid && ctl_i.last)) |=> ovfs_r)
    else $error("overflow flag dropped inside a polygon");

  // Accumulators hold when no move advances.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && ctl_i.valid) |=> ($stable(area_r) && $stable(perim_r)))
    else $error("accumulator changed without a move");

endmodule

FILE: rtl/rpa_result.sv
// Final lattice count formation and the output register.
module rpa_result (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               snap_valid_i,
  input  rpa_pkg::snap_t     snap_i,
  output logic               out_valid,
  output rpa_pkg::out_beat_t out_beat
);
  import rpa_pkg::*;

  logic                v3_r;
  logic [SUM_BITS-1:0] dbl_r;
  logic [SUM_BITS-1:0] perim3_r;
  logic                ovf3_r;

  logic                out_valid_r;
  out_beat_t           out_beat_r, out_beat_nxt;
  logic [SUM_BITS+1:0] total;

  // Absolute value of the doubled area.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (advance) begin
      v3_r <= snap_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && snap_valid_i) begin
      dbl_r    <= snap_i.area[SUM_BITS-1] ? (SUM_BITS'(0) - snap_i.area) : snap_i.area;
      perim3_r <= snap_i.perim;
      ovf3_r   <= snap_i.ovf;
    end
  end

  // Count = (|2A| + P)/2 + 1, formed as (|2A| + P + 2) >> 1 in one add.
  always_comb begin
    total = (SUM_BITS+2)'(dbl_r) + (SUM_BITS+2)'(perim3_r) + (SUM_BITS+2)'(2);
    out_beat_nxt.lattice_count   = total[SUM_BITS:1];
    out_beat_nxt.doubled_area    = dbl_r;
    out_beat_nxt.boundary_length = perim3_r;
    out_beat_nxt.overflow        = ovf3_r || (total[SUM_BITS:1] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v3_r) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: rtl/rectilinear_polygon_area.sv
// Top level of the rectilinear polygon area and lattice point counter.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------
//   in      | input     | in_valid / in_stall | in_beat (in_beat_t)
//   out     | output    | out_valid/out_stall | out_beat (out_beat_t)
//   cfg     | input     | cfg_valid/cfg_ready | cfg_data (encoded_mode)
//
// One move beat is taken every cycle while in_stall is low; the y-position feedback
// and the area accumulator add each update their register from its own value, which sets that rate.
// A closing move raises out_valid with its result after the input, product, snapshot, magnitude and output registers.
// Reset is synchronous and clears position, sums, mode and all valid bits.
// The whole pipeline holds only while a result waits and out_stall is high.
module rectilinear_polygon_area #(
  parameter int COORD_BITS = rpa_pkg::COORD_BITS_DEF,
  parameter int STEP_BITS  = rpa_pkg::STEP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpa_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output rpa_pkg::out_beat_t out_beat,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import rpa_pkg::*;

  logic                            advance;
  logic                            mode_r;
  mul_ctl_t                        mul_ctl;
  logic [COORD_BITS+STEP_BITS-1:0] prod;
  logic [STEP_BITS-1:0]            steps;
  logic                            snap_valid;
  snap_t                           snap;

  // The pipeline moves unless a waiting result is held off.
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  rpa_move #(
    .COORD_BITS(COORD_BITS),
    .STEP_BITS (STEP_BITS)
  ) u_move (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .in_valid    (in_valid),
    .in_beat     (in_beat),
    .encoded_mode(mode_r),
    .ctl_o       (mul_ctl),
    .prod_o      (prod),
    .steps_o     (steps)
  );

  rpa_accum #(
    .COORD_BITS(COORD_BITS),
    .STEP_BITS (STEP_BITS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .ctl_i       (mul_ctl),
    .prod_i      (prod),
    .steps_i     (steps),
    .snap_valid_o(snap_valid),
    .snap_o      (snap)
  );

  rpa_result u_result (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .snap_valid_i(snap_valid),
    .snap_i      (snap),
    .out_valid   (out_valid),
    .out_beat    (out_beat)
  );

endmodule
